### design/dlsc_pkg.sv
package dlsc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int OUT_W      = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPLIT_TOTAL      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_TOLERANCE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_THRESHOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_RATIO_BOUND = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOSS_MODE        = 3'd4;

    localparam logic [7:0] SPLIT_TOTAL_RST      = 8'd32;
    localparam logic [9:0] DELAY_TOLERANCE_RST  = 10'd20;
    localparam logic [5:0] STEP_THRESHOLD_RST   = 6'd3;
    localparam logic [7:0] LOSS_RATIO_BOUND_RST = 8'd2;
    localparam logic       LOSS_MODE_RST        = 1'b1;

    localparam logic [7:0]        SHARE_RST = 8'd32;
    localparam logic signed [7:0] GAIN_MAX  = 8'sd127;
    localparam logic signed [7:0] GAIN_MIN  = -8'sd127;
    localparam logic signed [7:0] GAIN_ONE  = 8'sd1;
    localparam logic signed [7:0] GAIN_NEG  = -8'sd1;
    localparam logic signed [7:0] GAIN_ZERO = 8'sd0;

    typedef struct packed {
        logic [7:0] split_total;
        logic [9:0] delay_tolerance;
        logic [5:0] step_threshold;
        logic [7:0] loss_ratio_bound;
        logic       loss_mode;
    } t_cfg;

    typedef struct packed {
        logic              split_changed;
        logic [7:0]        first_share;
        logic [7:0]        second_share;
        logic              loss_triggered;
        logic signed [7:0] gain;
    } t_step_res;

endpackage

### design/dlsc_cfg_regs.sv
module dlsc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dlsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dlsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output dlsc_pkg::t_cfg                  o_cfg
);
    import dlsc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_total      <= SPLIT_TOTAL_RST;
            r_cfg.delay_tolerance  <= DELAY_TOLERANCE_RST;
            r_cfg.step_threshold   <= STEP_THRESHOLD_RST;
            r_cfg.loss_ratio_bound <= LOSS_RATIO_BOUND_RST;
            r_cfg.loss_mode        <= LOSS_MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPLIT_TOTAL:      r_cfg.split_total      <= i_cfg_wdata[7:0];
                CFG_DELAY_TOLERANCE:  r_cfg.delay_tolerance  <= i_cfg_wdata[9:0];
                CFG_STEP_THRESHOLD:   r_cfg.step_threshold   <= i_cfg_wdata[5:0];
                CFG_LOSS_RATIO_BOUND: r_cfg.loss_ratio_bound <= i_cfg_wdata[7:0];
                CFG_LOSS_MODE:        r_cfg.loss_mode        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/dlsc_step.sv
module dlsc_step #(
    parameter int DELAY_BITS = 16,
    parameter int RUN_BITS   = 16
) (
    input  dlsc_pkg::t_cfg                i_cfg,
    input  logic signed [DELAY_BITS-1:0]  i_first_delay,
    input  logic signed [DELAY_BITS-1:0]  i_second_delay,
    input  logic [RUN_BITS-1:0]           i_first_run,
    input  logic [RUN_BITS-1:0]           i_second_run,
    input  logic signed [DELAY_BITS-1:0]  i_prev_first_delay,
    input  logic signed [DELAY_BITS-1:0]  i_prev_second_delay,
    input  logic [7:0]                    i_share,
    input  logic signed [7:0]             i_gain,
    output dlsc_pkg::t_step_res           o_res
);
    import dlsc_pkg::*;

    logic signed [DELAY_BITS+1:0] diff12, diff21, tol_ext;
    logic                         gt1, gt2;
    logic [RUN_BITS+7:0]          prod1, prod2;
    logic                         loss_dn, loss_up;
    logic signed [7:0]            g0;
    logic                         dn, up, by_loss;
    logic signed [8:0]            step_dn, step_up;
    logic signed [9:0]            sum_dn, sum_up;
    logic [7:0]                   share_dn, share_up, share_nx;
    logic signed [7:0]            gain_nx;

    assign diff12  = {{2{i_first_delay[DELAY_BITS-1]}}, i_first_delay}
                   - {{2{i_second_delay[DELAY_BITS-1]}}, i_second_delay};
    assign diff21  = -diff12;
    assign tol_ext = $signed({{(DELAY_BITS-8){1'b0}}, i_cfg.delay_tolerance});
    assign gt1     = diff12 > tol_ext;
    assign gt2     = diff21 > tol_ext;

    assign prod1   = {{8{1'b0}}, i_first_run} * {{RUN_BITS{1'b0}}, i_cfg.loss_ratio_bound};
    assign prod2   = {{8{1'b0}}, i_second_run} * {{RUN_BITS{1'b0}}, i_cfg.loss_ratio_bound};
    assign loss_dn = {{8{1'b0}}, i_second_run} > prod1;
    assign loss_up = {{8{1'b0}}, i_first_run} > prod2;

    always_comb begin
        g0      = i_gain;
        dn      = 1'b0;
        up      = 1'b0;
        by_loss = 1'b0;
        if (gt1) begin
            if (i_gain >= GAIN_ZERO) g0 = GAIN_NEG;
            dn = (i_first_delay >= i_prev_first_delay) && (i_share != 8'd0);
        end else if (gt2) begin
            if (i_gain <= GAIN_ZERO) g0 = GAIN_ONE;
            up = (i_second_delay >= i_prev_second_delay) && (i_share < i_cfg.split_total);
        end else if (!i_cfg.loss_mode) begin
            g0 = GAIN_ZERO;
        end else if (loss_dn) begin
            if (i_gain >= GAIN_ZERO) g0 = GAIN_NEG;
            dn      = i_share != 8'd0;
            by_loss = dn;
        end else if (loss_up) begin
            if (i_gain <= GAIN_ZERO) g0 = GAIN_ONE;
            up      = i_share < i_cfg.split_total;
            by_loss = up;
        end else begin
            g0 = GAIN_ZERO;
        end
    end

    // step sizes grow once the gain passes the threshold
    always_comb begin
        step_dn = {g0[7], g0} + $signed({3'b000, i_cfg.step_threshold});
        if (step_dn > -9'sd1) step_dn = -9'sd1;
        step_up = {g0[7], g0} - $signed({3'b000, i_cfg.step_threshold});
        if (step_up < 9'sd1) step_up = 9'sd1;
        sum_dn = $signed({2'b00, i_share}) + {step_dn[8], step_dn};
        sum_up = $signed({2'b00, i_share}) + {step_up[8], step_up};
        share_dn = (sum_dn < 10'sd0) ? 8'd0 : sum_dn[7:0];
        share_up = (sum_up > $signed({2'b00, i_cfg.split_total})) ? i_cfg.split_total
                                                                  : sum_up[7:0];
    end

    always_comb begin
        share_nx = i_share;
        gain_nx  = g0;
        if (dn) begin
            share_nx = share_dn;
            if (g0 != GAIN_MIN) gain_nx = g0 - GAIN_ONE;
        end else if (up) begin
            share_nx = share_up;
            if (g0 != GAIN_MAX) gain_nx = g0 + GAIN_ONE;
        end
    end

    assign o_res.split_changed  = dn | up;
    assign o_res.first_share    = share_nx;
    assign o_res.second_share   = (share_nx > i_cfg.split_total) ? 8'd0
                                                                 : i_cfg.split_total - share_nx;
    assign o_res.loss_triggered = by_loss;
    assign o_res.gain           = gain_nx;

endmodule

### design/dual_link_split_controller_core.sv
// Two-link split controller. Each input word carries both links' one-way
// delays and loss-free run lengths; each produces exactly one output word
// with the changed flag, both shares and the loss flag. One word is taken per
// clock cycle while the output is not stalled; a result passes the input
// register, then the step logic into the output register. The share and gain
// registers feed back through the step logic into themselves. Configuration
// registers take effect on the next word; write them only while no word is in
// flight.
module dual_link_split_controller_core #(
    parameter int DELAY_BITS = 16,
    parameter int RUN_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dlsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dlsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // first_delay, second_delay, first_run, second_run, zero pad
    input  logic [((2*DELAY_BITS+2*RUN_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // split_changed, first_share, second_share, loss_triggered, zero pad
    output logic [dlsc_pkg::OUT_W-1:0]      o_m_axis_tdata
);
    import dlsc_pkg::*;

    t_cfg      cfg;
    t_step_res res;

    logic                         r_in_valid;
    logic signed [DELAY_BITS-1:0] r_first_delay, r_second_delay;
    logic [RUN_BITS-1:0]          r_first_run, r_second_run;
    logic                         r_out_valid;
    logic [OUT_W-1:0]             r_out_data;
    logic [7:0]                   r_share;
    logic signed [7:0]            r_gain;
    logic signed [DELAY_BITS-1:0] r_prev_first, r_prev_second;
    logic                         out_free, fire, take;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign fire     = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign take     = i_s_axis_tvalid && o_s_axis_tready;

    dlsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dlsc_step #(
        .DELAY_BITS (DELAY_BITS),
        .RUN_BITS   (RUN_BITS)
    ) u_step (
        .i_cfg               (cfg),
        .i_first_delay       (r_first_delay),
        .i_second_delay      (r_second_delay),
        .i_first_run         (r_first_run),
        .i_second_run        (r_second_run),
        .i_prev_first_delay  (r_prev_first),
        .i_prev_second_delay (r_prev_second),
        .i_share             (r_share),
        .i_gain              (r_gain),
        .o_res               (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_share       <= SHARE_RST;
            r_gain        <= GAIN_ZERO;
            r_prev_first  <= '0;
            r_prev_second <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid   <= 1'b1;
                r_share       <= res.first_share;
                r_gain        <= res.gain;
                r_prev_first  <= r_first_delay;
                r_prev_second <= r_second_delay;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_first_delay  <= i_s_axis_tdata[DELAY_BITS-1:0];
            r_second_delay <= i_s_axis_tdata[2*DELAY_BITS-1:DELAY_BITS];
            r_first_run    <= i_s_axis_tdata[2*DELAY_BITS+RUN_BITS-1:2*DELAY_BITS];
            r_second_run   <= i_s_axis_tdata[2*DELAY_BITS+2*RUN_BITS-1:2*DELAY_BITS+RUN_BITS];
        end
        if (fire) begin
            r_out_data <= {6'b000000, res.loss_triggered, res.second_share,
                           res.first_share, res.split_changed};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### design/dlsc_checker.sv
module dlsc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [dlsc_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import dlsc_pkg::*;

    logic [8:0] share_sum;
    assign share_sum = {1'b0, o_m_axis_tdata[8:1]} + {1'b0, o_m_axis_tdata[16:9]};

    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output word changed");

    a_loss_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[17] && !o_m_axis_tdata[0]))
        else $error("loss flag without a change");

    a_share_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[16:9] != 8'd0 |-> share_sum <= 9'd255)
        else $error("shares exceed any total");

endmodule

bind dual_link_split_controller_core dlsc_checker u_dlsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
